// ===== design/graph_bfs_engine_top_macros.svh =====
// Assertion macros for the graph search engine checker
`ifndef GRAPH_BFS_ENGINE_TOP_MACROS_SVH
`define GRAPH_BFS_ENGINE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset
`define GBE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication with the consequent checked in the cycle after the antecedent
`define GBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/gbe_pkg.sv =====
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants of the graph search engine.
// ----------------------------------------------------------------------------
`default_nettype none
package gbe_pkg;
  localparam int MaxVertices = 32;
  localparam int MaxDegree   = 16;
  localparam int VW = 5;
  localparam int DW = $clog2(MaxDegree + 1);
  localparam int SW = $clog2(MaxDegree);
  localparam int AW = VW + SW;
  localparam int NW = VW + 1;

  localparam logic [DW-1:0] DegreeLimit = DW'(MaxDegree);
  localparam logic [NW-1:0] QueueLimit  = NW'(MaxVertices);
  localparam logic [DW-1:0] DegOne      = DW'(1);
  localparam logic [NW-1:0] PtrOne      = NW'(1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] EV_DEQ      = 3'd0;
  localparam logic [2:0] EV_DISC     = 3'd1;
  localparam logic [2:0] EV_DONE     = 3'd2;
  localparam logic [2:0] EV_SELF     = 3'd3;
  localparam logic [2:0] EV_FULL     = 3'd4;
  localparam logic [2:0] EV_BADSTART = 3'd5;

  // Write port of the neighbour memory
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [VW-1:0] data;
  } nbr_wr_t;
endpackage
`default_nettype wire

// ===== design/graph_bfs_engine_top.sv =====
// ----------------------------------------------------------------------------
// graph_bfs_engine_top
// Graph store with breadth-first walk, neighbour lists in a synchronous RAM.
// ----------------------------------------------------------------------------
// channel | direction | handshake    | fields
// in      | input     | valid/stall  | mode first_vertex second_vertex start_vertex
// out     | output    | valid/stall  | vertex event_res last
// Single-word results are valid the cycle after the input is taken; an added
// edge first makes its two neighbour writes, in S_ADD and then S_ADD2.
// Search passes S_DEQ per dequeued vertex, then S_SCAN and S_CHK per neighbour
// entry (read, then check), as the neighbour RAM has a single read port.
// Each word is held one step until its successor is known, so a new word
// waits while the previous one still sits unaccepted at the output.
// Input stays stalled until the final word is taken. Reset clears degrees,
// vertex count and visited bits at once; no sweep.
`default_nettype none
module graph_bfs_engine_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [4:0] first_vertex,
  input  wire logic [4:0] second_vertex,
  input  wire logic [4:0] start_vertex,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      vertex,
  output logic [2:0]      event_res,
  output logic            last
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_ADD2  = 6'b000100,
    S_DEQ   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_CHK   = 6'b100000
  } state_t;

  state_t state;
  logic [gbe_pkg::DW-1:0] degree [gbe_pkg::MaxVertices];
  logic [gbe_pkg::MaxVertices-1:0] visited;
  logic [gbe_pkg::NW-1:0] vcount;
  logic [gbe_pkg::VW-1:0] queue [gbe_pkg::MaxVertices];
  logic [gbe_pkg::NW-1:0] qhead, qtail;
  logic [gbe_pkg::VW-1:0] va, vb, cur;
  logic [gbe_pkg::DW-1:0] idx;
  // word held back until its successor is known
  logic [gbe_pkg::VW-1:0] pvert;
  logic [2:0] pev;
  logic pvalid;
  logic accept, add_ok, start_ok, found, out_load;
  gbe_pkg::nbr_wr_t wr;
  logic [gbe_pkg::AW-1:0] raddr;
  logic [gbe_pkg::VW-1:0] rdata;

  gbe_nbr_mem u_mem (.clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata));

  assign in_stall = (state != S_IDLE) || out_valid;
  assign raddr = {cur, idx[gbe_pkg::SW-1:0]};
  assign accept = in_valid && !in_stall;
  assign add_ok = (first_vertex != second_vertex) &&
                  (degree[first_vertex] < gbe_pkg::DegreeLimit) &&
                  (degree[second_vertex] < gbe_pkg::DegreeLimit);
  assign start_ok = {1'b0, start_vertex} < vcount;
  assign found = !visited[rdata] && (qtail < gbe_pkg::QueueLimit);

  always_comb begin
    wr = '0;
    if (state == S_ADD) begin
      wr.we = 1'b1;
      wr.addr = {va, degree[va][gbe_pkg::SW-1:0]};
      wr.data = vb;
    end else if (state == S_ADD2) begin
      wr.we = 1'b1;
      wr.addr = {vb, degree[vb][gbe_pkg::SW-1:0]};
      wr.data = va;
    end
  end

  // a word enters the output register only while it is empty
  always_comb begin
    unique case (state)
      S_IDLE: out_load = accept &&
                         ((mode == gbe_pkg::MODE_ADD && !add_ok) ||
                          (mode == gbe_pkg::MODE_SEARCH && !start_ok) ||
                          (mode == gbe_pkg::MODE_CLEAR));
      S_ADD2: out_load = 1'b1;
      S_DEQ:  out_load = pvalid && !out_valid;
      S_CHK:  out_load = found && !out_valid;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      visited <= '0;
      vcount <= '0;
      qhead <= '0;
      qtail <= '0;
      pvalid <= 1'b0;
      for (int i = 0; i < gbe_pkg::MaxVertices; i++) degree[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            va <= first_vertex;
            vb <= second_vertex;
            last <= 1'b1;
            unique case (mode)
              gbe_pkg::MODE_ADD: begin
                if (first_vertex == second_vertex) begin
                  vertex <= first_vertex; event_res <= gbe_pkg::EV_SELF;
                end else if (degree[first_vertex] >= gbe_pkg::DegreeLimit) begin
                  vertex <= first_vertex; event_res <= gbe_pkg::EV_FULL;
                end else if (degree[second_vertex] >= gbe_pkg::DegreeLimit) begin
                  vertex <= second_vertex; event_res <= gbe_pkg::EV_FULL;
                end else begin
                  state <= S_ADD;
                end
              end
              gbe_pkg::MODE_SEARCH: begin
                if (!start_ok) begin
                  vertex <= start_vertex; event_res <= gbe_pkg::EV_BADSTART;
                end else begin
                  visited <= {{(gbe_pkg::MaxVertices-1){1'b0}}, 1'b1} << start_vertex;
                  queue[0] <= start_vertex;
                  qhead <= '0;
                  qtail <= gbe_pkg::PtrOne;
                  pvalid <= 1'b0;
                  state <= S_DEQ;
                end
              end
              gbe_pkg::MODE_CLEAR: begin
                vertex <= '0; event_res <= gbe_pkg::EV_DONE;
                vcount <= '0;
                visited <= '0;
                for (int i = 0; i < gbe_pkg::MaxVertices; i++) degree[i] <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          degree[va] <= degree[va] + gbe_pkg::DegOne;
          state <= S_ADD2;
        end
        S_ADD2: begin
          degree[vb] <= degree[vb] + gbe_pkg::DegOne;
          if (({1'b0, va} + gbe_pkg::PtrOne) > vcount && va > vb)
            vcount <= {1'b0, va} + gbe_pkg::PtrOne;
          else if (({1'b0, vb} + gbe_pkg::PtrOne) > vcount && vb > va)
            vcount <= {1'b0, vb} + gbe_pkg::PtrOne;
          vertex <= va; event_res <= gbe_pkg::EV_DONE; last <= 1'b1;
          state <= S_IDLE;
        end
        S_DEQ: begin
          if (qhead < qtail) begin
            if (!(pvalid && out_valid)) begin
              if (pvalid) begin
                vertex <= pvert; event_res <= pev; last <= 1'b0;
              end
              pvert <= queue[qhead[gbe_pkg::VW-1:0]];
              pev <= gbe_pkg::EV_DEQ;
              pvalid <= 1'b1;
              cur <= queue[qhead[gbe_pkg::VW-1:0]];
              qhead <= qhead + gbe_pkg::PtrOne;
              idx <= '0;
              state <= S_SCAN;
            end
          end else if (!out_valid) begin
            // queue drained: the held word is the final one
            vertex <= pvert; event_res <= pev; last <= 1'b1;
            pvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // issue read of entry idx; data arrives next cycle
          if (idx >= degree[cur]) begin
            state <= S_DEQ;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!found) begin
            idx <= idx + gbe_pkg::DegOne;
            state <= S_SCAN;
          end else if (!out_valid) begin
            vertex <= pvert; event_res <= pev; last <= 1'b0;
            pvert <= rdata;
            pev <= gbe_pkg::EV_DISC;
            visited[rdata] <= 1'b1;
            queue[qtail[gbe_pkg::VW-1:0]] <= rdata;
            qtail <= qtail + gbe_pkg::PtrOne;
            idx <= idx + gbe_pkg::DegOne;
            state <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/gbe_nbr_mem.sv =====
// ----------------------------------------------------------------------------
// gbe_nbr_mem
// Neighbour list memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gbe_nbr_mem (
  input  wire logic                   clk,
  input  wire gbe_pkg::nbr_wr_t       wr,
  input  wire logic [gbe_pkg::AW-1:0] raddr,
  output logic      [gbe_pkg::VW-1:0] rdata
);
  logic [gbe_pkg::VW-1:0] mem [0:(1 << gbe_pkg::AW) - 1];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/gbe_checker.sv =====
// ----------------------------------------------------------------------------
// gbe_checker
// Port-level checks of the graph search engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_bfs_engine_top_macros.svh"
module gbe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [4:0] vertex,
  input wire logic [2:0] event_res,
  input wire logic       last
);
  `GBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(vertex), "word moved")
  `GBE_ASSERT_IMPL(a_event_range, out_valid, event_res <= gbe_pkg::EV_BADSTART, "bad event")
  `GBE_ASSERT_IMPL(a_single_last, out_valid && event_res >= gbe_pkg::EV_DONE, last, "not last")
  `GBE_ASSERT_IMPL(a_busy_stall, out_valid, in_stall, "input taken while word pending")
endmodule
bind graph_bfs_engine_top gbe_checker u_chk (.*);
`default_nettype wire
